### rtl/gwm_pkg.sv
// ---------------------------------------------------------------------------
// Glob wildcard matcher package
// Shared constants, operation codes and the command struct.
// ---------------------------------------------------------------------------
package gwm_pkg;

	localparam int PATTERN_CAPACITY_DEF = 32;
	localparam int OP_W  = 2;
	localparam int SYM_W = 8;

	localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;
	localparam logic [SYM_W-1:0] ANY_BYTE  = 8'h3F;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_SUBJECT = 2'd2,
		OP_END     = 2'd3
	} op_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic consume;
		logic finish;
	} gwm_cmd_t;

endpackage

### rtl/gwm_item_if.sv
// ---------------------------------------------------------------------------
// Glob wildcard matcher item channel
// Carries one operation word with its symbol byte.
// ---------------------------------------------------------------------------
interface gwm_item_if;
	import gwm_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [SYM_W-1:0] symbol;

	modport source (output valid, output operation, output symbol, input ready);
	modport sink   (input valid, input operation, input symbol, output ready);
endinterface

### rtl/gwm_result_if.sv
// ---------------------------------------------------------------------------
// Glob wildcard matcher result channel
// Carries one verdict word per subject.
// ---------------------------------------------------------------------------
interface gwm_result_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

### rtl/gwm_pattern_store.sv
// ---------------------------------------------------------------------------
// Glob wildcard matcher pattern store
// Holds the pattern bytes, its length, the overflow flag and the restart
// set of positions reachable through leading stars; decodes per-position
// star and byte-hit masks for the subject byte in hand.
// ---------------------------------------------------------------------------
module gwm_pattern_store #(
	parameter int CAP   = gwm_pkg::PATTERN_CAPACITY_DEF,
	parameter int LEN_W = $clog2(CAP + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gwm_pkg::gwm_cmd_t      cmd,
	input  logic [gwm_pkg::SYM_W-1:0] symbol,
	output logic [LEN_W-1:0]       len,
	output logic                   overflow,
	output logic [CAP-1:0]         star_mask,
	output logic [CAP-1:0]         hit_mask,
	output logic [CAP:0]           restart_next
);
	import gwm_pkg::*;

	localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

	logic [SYM_W-1:0] bytes_q [CAP];
	logic [LEN_W-1:0] len_q;
	logic             overflow_q;
	logic             all_star_q;
	logic [CAP:0]     restart_q;
	logic             has_room;
	logic [LEN_W-1:0] len_inc;

	assign has_room = (len_q < LEN_W'(CAP));
	assign len_inc  = len_q + LEN_W'(1);

	always_comb begin
		for (int p = 0; p < CAP; p++) begin
			star_mask[p] = (LEN_W'(p) < len_q) && (bytes_q[p] == STAR_BYTE);
			hit_mask[p]  = (LEN_W'(p) < len_q) && (bytes_q[p] != STAR_BYTE) &&
				((bytes_q[p] == ANY_BYTE) || (bytes_q[p] == symbol));
		end
	end

	always_comb begin
		restart_next = restart_q;
		if (cmd.clear) begin
			restart_next = (CAP + 1)'(1);
		end else if (cmd.append && has_room && all_star_q && (symbol == STAR_BYTE)) begin
			for (int p = 0; p <= CAP; p++) begin
				if (LEN_W'(p) == len_inc) begin
					restart_next[p] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			overflow_q <= 1'b0;
			all_star_q <= 1'b1;
			restart_q  <= (CAP + 1)'(1);
		end else begin
			restart_q <= restart_next;
			if (cmd.clear) begin
				len_q      <= '0;
				overflow_q <= 1'b0;
				all_star_q <= 1'b1;
			end else if (cmd.append) begin
				if (has_room) begin
					len_q <= len_inc;
					if (symbol != STAR_BYTE) begin
						all_star_q <= 1'b0;
					end
				end else begin
					overflow_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append && has_room) begin
			bytes_q[len_q[IDX_W-1:0]] <= symbol;
		end
	end

	assign len      = len_q;
	assign overflow = overflow_q;
endmodule

### rtl/gwm_live_set.sv
// ---------------------------------------------------------------------------
// Glob wildcard matcher live position set
// Holds the set of live pattern positions. A subject byte advances it one
// step and a parallel prefix network closes the result over runs of stars.
// ---------------------------------------------------------------------------
module gwm_live_set #(
	parameter int CAP = gwm_pkg::PATTERN_CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic         step,
	input  logic [CAP:0] restart_next,
	input  logic [CAP-1:0] star_mask,
	input  logic [CAP-1:0] hit_mask,
	output logic [CAP:0] live
);
	localparam int LVL = $clog2(CAP + 1);

	logic [CAP:0] live_q;
	logic [CAP:0] raw;
	logic [CAP:0] gen [LVL+1];
	logic [CAP:0] prop [LVL+1];

	always_comb begin
		for (int p = 0; p <= CAP; p++) begin
			raw[p] = 1'b0;
			if (p < CAP) begin
				raw[p] = live_q[p] & star_mask[p];
			end
			if (p > 0) begin
				raw[p] = raw[p] | (live_q[p-1] & hit_mask[p-1]);
			end
		end
	end

	always_comb begin
		gen[0]     = raw;
		prop[0][0] = 1'b0;
		for (int p = 1; p <= CAP; p++) begin
			prop[0][p] = star_mask[p-1];
		end
		for (int d = 0; d < LVL; d++) begin
			for (int p = 0; p <= CAP; p++) begin
				if (p >= (1 << d)) begin
					gen[d+1][p]  = gen[d][p] | (prop[d][p] & gen[d][p-(1 << d)]);
					prop[d+1][p] = prop[d][p] & prop[d][p-(1 << d)];
				end else begin
					gen[d+1][p]  = gen[d][p];
					prop[d+1][p] = prop[d][p];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= (CAP + 1)'(1);
		end else if (load) begin
			live_q <= restart_next;
		end else if (step) begin
			live_q <= gen[LVL];
		end
	end

	assign live = live_q;
endmodule

### rtl/glob_wildcard_match_core.sv
// ---------------------------------------------------------------------------
// Glob wildcard match core
// Matches subject byte strings against a pattern in which a star matches
// any run of bytes and a question mark matches any single byte.
// ---------------------------------------------------------------------------
// Usage:
// Words arrive on the item channel: clear pattern, append pattern byte,
// subject byte or end of subject. Only an end of subject produces a word
// on the result channel, carrying the verdict and the overflow flag.
// A word accepted on the item channel is registered in the input stage
// and processed from there, which updates the pattern and live position
// set and, for an end of subject, loads the result register, from which
// the verdict is offered until the receiver takes it.
// One word is taken every cycle unless an end of subject is held in the
// input stage by a stalled result; the live set is updated by a single
// combinational step with a logarithmic star-closure network per cycle.
// When the receiver stalls, the result is held and input continues to
// flow until a further end of subject reaches the input stage, which
// then waits and holds item ready low until the result is taken.
// Reset clears the pattern, the overflow flag and both channel stages.
// Pattern bytes beyond the capacity are dropped and raise the flag.
// ---------------------------------------------------------------------------
module glob_wildcard_match_core #(
	parameter int PATTERN_CAPACITY = gwm_pkg::PATTERN_CAPACITY_DEF
) (
	input logic         clk,
	input logic         arst_n,
	gwm_item_if.sink    item,
	gwm_result_if.source result
);
	import gwm_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_CAPACITY + 1);

	logic                  valid_s1;
	op_t                   op_s1;
	logic [SYM_W-1:0]      symbol_s1;
	logic                  advance;
	logic                  fire;
	gwm_cmd_t              cmd;
	logic [LEN_W-1:0]      len;
	logic                  overflow;
	logic [PATTERN_CAPACITY-1:0] star_mask;
	logic [PATTERN_CAPACITY-1:0] hit_mask;
	logic [PATTERN_CAPACITY:0]   restart_next;
	logic [PATTERN_CAPACITY:0]   live;
	logic                  out_valid_q;
	logic                  matched_q;
	logic                  overflow_out_q;
	logic                  live_beyond;

	assign advance    = !(valid_s1 && (op_s1 == OP_END) && out_valid_q && !result.ready);
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_comb begin
		cmd = '0;
		if (fire) begin
			case (op_s1)
				OP_CLEAR:   cmd.clear   = 1'b1;
				OP_APPEND:  cmd.append  = 1'b1;
				OP_SUBJECT: cmd.consume = 1'b1;
				OP_END:     cmd.finish  = 1'b1;
				default:    cmd = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1     <= op_t'(item.operation);
			symbol_s1 <= item.symbol;
		end
	end

	gwm_pattern_store #(
		.CAP   (PATTERN_CAPACITY),
		.LEN_W (LEN_W)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.symbol       (symbol_s1),
		.len          (len),
		.overflow     (overflow),
		.star_mask    (star_mask),
		.hit_mask     (hit_mask),
		.restart_next (restart_next)
	);

	gwm_live_set #(
		.CAP (PATTERN_CAPACITY)
	) u_live (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (cmd.clear || cmd.append || cmd.finish),
		.step         (cmd.consume),
		.restart_next (restart_next),
		.star_mask    (star_mask),
		.hit_mask     (hit_mask),
		.live         (live)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			matched_q      <= live[len];
			overflow_out_q <= overflow;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.matched          = matched_q;
	assign result.pattern_overflow = overflow_out_q;

	always_comb begin
		live_beyond = 1'b0;
		for (int p = 0; p <= PATTERN_CAPACITY; p++) begin
			if ((LEN_W'(p) > len) && live[p]) begin
				live_beyond = 1'b1;
			end
		end
	end

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("end of subject did not load the result register");

	a_clear_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (len == '0) && (live == (PATTERN_CAPACITY + 1)'(1)) && !overflow)
		else $error("clear did not restart the pattern and live set");

	a_no_live_beyond_length: assert property (@(posedge clk) disable iff (!arst_n)
		!live_beyond)
		else $error("live position beyond pattern length");

	a_full_append_overflows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.append && (len == LEN_W'(PATTERN_CAPACITY))) |=>
			overflow && (len == LEN_W'(PATTERN_CAPACITY)))
		else $error("append to a full pattern did not raise overflow");
endmodule

### verif/glob_wildcard_match_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Glob wildcard match core testbench
// Drives clears, pattern appends, subject bytes and subject ends into the
// core with random gaps on both channels. It keeps its own copy of the
// pattern and the live position set and checks each verdict word in order.
// ---------------------------------------------------------------------------
module glob_wildcard_match_core_test;
	import gwm_pkg::*;

	localparam int CAP = PATTERN_CAPACITY_DEF;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	class glob_verdict_board;
		logic [SYM_W-1:0] pattern_text [CAP];
		int unsigned      pattern_len;
		logic [CAP:0]     live;
		bit               overflow;
		verdict_t         verdict_q[$];
		int               faults;
		int               verdicts;
		int               hit_count;
		int               flagged;

		function new();
			pattern_len = 0;
			overflow = 1'b0;
			faults = 0;
			verdicts = 0;
			hit_count = 0;
			flagged = 0;
			restart();
		endfunction

		function void close_stars();
			for (int p = 0; p < pattern_len; p++) begin
				if (live[p] && pattern_text[p] == STAR_BYTE)
					live[p+1] = 1'b1;
			end
		endfunction

		function void restart();
			live = '0;
			live[0] = 1'b1;
			close_stars();
		endfunction

		function void note_word(op_t op, logic [SYM_W-1:0] sym);
			logic [CAP:0] next_live;
			verdict_t     v;
			case (op)
				OP_CLEAR: begin
					pattern_len = 0;
					overflow = 1'b0;
					restart();
				end
				OP_APPEND: begin
					if (pattern_len < CAP) begin
						pattern_text[pattern_len] = sym;
						pattern_len++;
					end else begin
						overflow = 1'b1;
					end
					restart();
				end
				OP_SUBJECT: begin
					next_live = '0;
					for (int p = 0; p < pattern_len; p++) begin
						if (live[p]) begin
							if (pattern_text[p] == STAR_BYTE)
								next_live[p] = 1'b1;
							else if (pattern_text[p] == ANY_BYTE || pattern_text[p] == sym)
								next_live[p+1] = 1'b1;
						end
					end
					live = next_live;
					close_stars();
				end
				default: begin
					v.matched = live[pattern_len];
					v.overflow = overflow;
					verdict_q = {verdict_q, v};
					restart();
				end
			endcase
		endfunction

		function void check_verdict(logic matched, logic pattern_overflow);
			verdict_t v;
			if (verdict_q.size() == 0) begin
				$error("verdict word arrived with none outstanding");
				faults++;
				return;
			end
			v = verdict_q.pop_front();
			verdicts++;
			if (matched === 1'b1)
				hit_count++;
			if (pattern_overflow === 1'b1)
				flagged++;
			if (matched !== v.matched) begin
				$error("matched: expected %0b, actual %0b", v.matched, matched);
				faults++;
			end
			if (pattern_overflow !== v.overflow) begin
				$error("pattern_overflow: expected %0b, actual %0b",
					v.overflow, pattern_overflow);
				faults++;
			end
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	gwm_item_if   item_bus();
	gwm_result_if result_bus();

	glob_wildcard_match_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	glob_verdict_board board = new();

	bit quiet;
	bit hold_req;
	int words_sent;
	int stall_left;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (item_bus.valid === 1'b1 && item_bus.ready === 1'b1)
			board.note_word(op_t'(item_bus.operation), item_bus.symbol);
		if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
			board.check_verdict(result_bus.matched, result_bus.pattern_overflow);
	end

	initial begin
		result_bus.ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= quiet || $urandom_range(99) >= 35;
			end
			@(posedge clk);
		end
	end

	task automatic send_word(op_t op, logic [SYM_W-1:0] sym);
		while (!quiet && $urandom_range(99) < 35) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.operation <= op;
		item_bus.symbol <= sym;
		@(posedge clk);
		while (item_bus.ready !== 1'b1)
			@(posedge clk);
		words_sent++;
	endtask

	function automatic logic [SYM_W-1:0] pick_symbol();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return "a";
		else if (r < 50)
			return "b";
		else if (r < 65)
			return STAR_BYTE;
		else if (r < 78)
			return ANY_BYTE;
		else if (r < 88)
			return "c";
		return SYM_W'($urandom_range(255));
	endfunction

	initial begin
		logic [SYM_W-1:0] pat[$];
		logic [SYM_W-1:0] subj[$];
		int               len;
		int               stop_at;
		bit               hold_done;

		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.operation = OP_CLEAR;
		item_bus.symbol = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		words_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pattern against the empty subject and against one byte.
		send_word(OP_END, 8'hFF);
		send_word(OP_SUBJECT, "a");
		send_word(OP_END, 8'h00);
		// A lone star takes the empty subject, extreme bytes and a literal star.
		send_word(OP_APPEND, STAR_BYTE);
		send_word(OP_END, 8'h00);
		send_word(OP_SUBJECT, 8'h00);
		send_word(OP_SUBJECT, 8'hFF);
		send_word(OP_SUBJECT, STAR_BYTE);
		send_word(OP_END, 8'h00);
		// A question mark takes exactly one byte of any value.
		send_word(OP_CLEAR, 8'hFF);
		send_word(OP_APPEND, ANY_BYTE);
		send_word(OP_SUBJECT, 8'hFF);
		send_word(OP_END, 8'h00);
		send_word(OP_END, 8'h00);
		// A star in the subject is just another byte under the pattern star.
		send_word(OP_CLEAR, 8'h00);
		send_word(OP_APPEND, STAR_BYTE);
		send_word(OP_APPEND, "a");
		send_word(OP_SUBJECT, STAR_BYTE);
		send_word(OP_SUBJECT, "x");
		send_word(OP_SUBJECT, "a");
		send_word(OP_END, 8'h00);
		// Changing the pattern abandons the subject in progress.
		send_word(OP_SUBJECT, "b");
		send_word(OP_APPEND, ANY_BYTE);
		send_word(OP_SUBJECT, "a");
		send_word(OP_SUBJECT, 8'h00);
		send_word(OP_END, 8'h00);
		send_word(OP_SUBJECT, "q");
		send_word(OP_CLEAR, 8'h00);
		send_word(OP_END, 8'hFF);
		// Fill the pattern, then offer two bytes past the capacity.
		for (int i = 0; i < CAP; i++)
			send_word(OP_APPEND, STAR_BYTE);
		send_word(OP_APPEND, 8'hFF);
		send_word(OP_APPEND, 8'h00);
		send_word(OP_END, 8'h00);
		send_word(OP_SUBJECT, "z");
		send_word(OP_END, 8'h00);
		send_word(OP_CLEAR, 8'h00);
		send_word(OP_END, 8'h00);

		stop_at = words_sent + 1900;
		while (words_sent < stop_at) begin
			if (!hold_done && words_sent >= 700) begin
				quiet = 1'b1;
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (quiet && words_sent >= 1000)
				quiet = 1'b0;
			if ($urandom_range(99) < 8) begin
				repeat ($urandom_range(1, 12))
					send_word(op_t'($urandom_range(3)), SYM_W'($urandom_range(255)));
			end else begin
				send_word(OP_CLEAR, SYM_W'($urandom_range(255)));
				len = ($urandom_range(14) == 0) ? $urandom_range(28, 36)
				                                : $urandom_range(0, 8);
				pat.delete();
				repeat (len) begin
					pat = {pat, pick_symbol()};
					send_word(OP_APPEND, pat[$]);
				end
				repeat ($urandom_range(1, 6)) begin
					subj.delete();
					if ($urandom_range(1) == 1) begin
						for (int i = 0; i < pat.size() && i < CAP; i++) begin
							if (pat[i] == STAR_BYTE)
								repeat ($urandom_range(0, 3)) subj = {subj, pick_symbol()};
							else if (pat[i] == ANY_BYTE)
								subj = {subj, SYM_W'($urandom_range(255))};
							else
								subj = {subj, pat[i]};
						end
					end else begin
						repeat ($urandom_range(0, 10)) subj = {subj, pick_symbol()};
					end
					if (subj.size() > 0 && $urandom_range(4) == 0)
						subj[$urandom_range(subj.size() - 1)] = pick_symbol();
					foreach (subj[i])
						send_word(OP_SUBJECT, subj[i]);
					if ($urandom_range(19) == 0) begin
						pat = {pat, pick_symbol()};
						send_word(OP_APPEND, pat[$]);
					end else begin
						send_word(OP_END, SYM_W'($urandom_range(255)));
					end
				end
			end
		end
		item_bus.valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d words and checked %0d verdicts.", words_sent, board.verdicts);
		$display("%0d verdicts matched and %0d carried the overflow flag.",
			board.hit_count, board.flagged);
		if (board.faults == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
